// File: rtl/bwpt_pkg.sv
// Shared constants, types and fixed-point helpers for the bone world position transform.
package bwpt_pkg;

  localparam int unsigned StepW = 5;

  localparam logic [StepW-1:0] LoadLast = StepW'(22);
  localparam logic [StepW-1:0] BoneLast = StepW'(11);

  localparam logic signed [31:0] QOne = 32'sh0001_0000;
  localparam logic signed [31:0] QMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] QMin = 32'sh8000_0000;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdBone = 1'b1;

  typedef struct packed {
    logic             run;
    logic             capture;
    logic             is_bone;
    logic             emit;
    logic [StepW-1:0] step;
  } ctrl_cmd_t;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] s);
    logic signed [31:0] r;
    if (s > 33'sh0_7FFF_FFFF) begin
      r = QMax;
    end else if (s < -33'sh0_8000_0000) begin
      r = QMin;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    return sat33(s);
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} - {b[31], b};
    return sat33(s);
  endfunction

  // Round half up, drop 16 fraction bits and saturate a full product.
  function automatic logic signed [31:0] qround(input logic signed [63:0] p);
    logic signed [63:0] sum;
    logic signed [63:0] sh;
    logic signed [31:0] r;
    sum = p + 64'sh8000;
    sh  = sum >>> 16;
    if (sh > 64'sh0000_0000_7FFF_FFFF) begin
      r = QMax;
    end else if (sh < -64'sh0000_0000_8000_0000) begin
      r = QMin;
    end else begin
      r = sh[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/bone_world_position_transform.sv
// Top level of the bone world position transform.
// A load request occupies the block until the stored matrix is complete; no new request is taken meanwhile.
// A bone request occupies the block until its result can enter the output register.
// Both kinds of request use one shared 32x32 multiplier that handles every product in turn.
// A result waiting in the output register does not block a new request.
// Reset clears the stored matrix and translation to zero and leaves the block idle.
module bone_world_position_transform (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  logic signed [31:0] rot_x_i,
  input  logic signed [31:0] rot_y_i,
  input  logic signed [31:0] rot_z_i,
  input  logic signed [31:0] rot_w_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] scale_x_i,
  input  logic signed [31:0] scale_y_i,
  input  logic signed [31:0] scale_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] world_x_o,
  output logic signed [31:0] world_y_o,
  output logic signed [31:0] world_z_o
);

  bwpt_pkg::ctrl_cmd_t ctrl;

  bwpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .ctrl_o     (ctrl)
  );

  bwpt_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .cmd_i    (cmd_i),
    .rot_x_i  (rot_x_i),
    .rot_y_i  (rot_y_i),
    .rot_z_i  (rot_z_i),
    .rot_w_i  (rot_w_i),
    .pos_x_i  (pos_x_i),
    .pos_y_i  (pos_y_i),
    .pos_z_i  (pos_z_i),
    .scale_x_i(scale_x_i),
    .scale_y_i(scale_y_i),
    .scale_z_i(scale_z_i),
    .world_x_o(world_x_o),
    .world_y_o(world_y_o),
    .world_z_o(world_z_o)
  );

endmodule

// File: rtl/bwpt_ctrl.sv
// Controller state machine that sequences the shared multiplier steps and the result handshake.
module bwpt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bwpt_pkg::ctrl_cmd_t ctrl_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e                     state_q, state_d;
  logic [bwpt_pkg::StepW-1:0] step_q, step_d;
  logic                       bone_q, bone_d;
  logic                       out_valid_q, out_valid_d;
  logic                       accept;
  logic                       last;
  logic                       emit;

  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign last   = bone_q ? (step_q == bwpt_pkg::BoneLast) : (step_q == bwpt_pkg::LoadLast);
  assign emit   = (state_q == ST_RUN) && bone_q && (step_q == bwpt_pkg::BoneLast) &&
                  (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    bone_d  = bone_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RUN;
          step_d  = '0;
          bone_d  = (cmd_i == bwpt_pkg::CmdBone);
        end
      end
      ST_RUN: begin
        if (!last) begin
          step_d = step_q + 1'b1;
        end else if (!bone_q || emit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = emit || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      bone_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      bone_q      <= bone_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign ctrl_o.run     = (state_q == ST_RUN);
  assign ctrl_o.capture = accept;
  assign ctrl_o.is_bone = bone_q;
  assign ctrl_o.emit    = emit;
  assign ctrl_o.step    = step_q;

endmodule

// File: rtl/bwpt_datapath.sv
// Datapath with the shared multiplier, rounding stage, matrix registers and result registers.
module bwpt_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bwpt_pkg::ctrl_cmd_t       ctrl_i,
  input  logic                      cmd_i,
  input  logic signed [31:0]        rot_x_i,
  input  logic signed [31:0]        rot_y_i,
  input  logic signed [31:0]        rot_z_i,
  input  logic signed [31:0]        rot_w_i,
  input  logic signed [31:0]        pos_x_i,
  input  logic signed [31:0]        pos_y_i,
  input  logic signed [31:0]        pos_z_i,
  input  logic signed [31:0]        scale_x_i,
  input  logic signed [31:0]        scale_y_i,
  input  logic signed [31:0]        scale_z_i,
  output logic signed [31:0]        world_x_o,
  output logic signed [31:0]        world_y_o,
  output logic signed [31:0]        world_z_o
);

  logic signed [31:0] x_q, y_q, z_q, w_q;
  logic signed [31:0] x2_q, y2_q, z2_q;
  logic signed [31:0] sx_q, sy_q, sz_q;
  logic signed [31:0] px_q, py_q, pz_q;
  logic signed [31:0] t_q [9];
  logic signed [31:0] m_q [12];
  logic signed [31:0] f_q, f_d;
  logic signed [63:0] prod_q;
  logic signed [31:0] r_q;
  logic signed [31:0] acc_q;
  logic signed [31:0] w0_q, w1_q;
  logic signed [31:0] world_q [3];
  logic signed [31:0] mul_a, mul_b;
  logic [4:0]         st;
  logic               load_run;
  logic               bone_run;

  assign st       = ctrl_i.step;
  assign load_run = ctrl_i.run && !ctrl_i.is_bone;
  assign bone_run = ctrl_i.run && ctrl_i.is_bone;

  always_comb begin
    mul_a = f_q;
    mul_b = sx_q;
    if (bone_run) begin
      case (st)
        5'd0: begin mul_a = px_q; mul_b = m_q[0]; end
        5'd1: begin mul_a = py_q; mul_b = m_q[3]; end
        5'd2: begin mul_a = pz_q; mul_b = m_q[6]; end
        5'd3: begin mul_a = px_q; mul_b = m_q[1]; end
        5'd4: begin mul_a = py_q; mul_b = m_q[4]; end
        5'd5: begin mul_a = pz_q; mul_b = m_q[7]; end
        5'd6: begin mul_a = px_q; mul_b = m_q[2]; end
        5'd7: begin mul_a = py_q; mul_b = m_q[5]; end
        5'd8: begin mul_a = pz_q; mul_b = m_q[8]; end
        default: begin mul_a = px_q; mul_b = m_q[0]; end
      endcase
    end else begin
      case (st)
        5'd0: begin mul_a = x_q; mul_b = x2_q; end
        5'd1: begin mul_a = y_q; mul_b = y2_q; end
        5'd2: begin mul_a = z_q; mul_b = z2_q; end
        5'd3: begin mul_a = y_q; mul_b = z2_q; end
        5'd4: begin mul_a = x_q; mul_b = y2_q; end
        5'd5: begin mul_a = x_q; mul_b = z2_q; end
        5'd6: begin mul_a = w_q; mul_b = x2_q; end
        5'd7: begin mul_a = w_q; mul_b = y2_q; end
        5'd8: begin mul_a = w_q; mul_b = z2_q; end
        default: begin
          mul_a = f_q;
          if (st inside {[5'd12:5'd14]}) begin
            mul_b = sx_q;
          end else if (st inside {[5'd15:5'd17]}) begin
            mul_b = sy_q;
          end else begin
            mul_b = sz_q;
          end
        end
      endcase
    end
  end

  // Products in t_q: xx2 yy2 zz2 yz2 xy2 xz2 wx2 wy2 wz2.
  always_comb begin
    case (st)
      5'd11:   f_d = bwpt_pkg::qsub(bwpt_pkg::QOne, bwpt_pkg::qadd(t_q[1], t_q[2]));
      5'd12:   f_d = bwpt_pkg::qadd(t_q[4], t_q[8]);
      5'd13:   f_d = bwpt_pkg::qsub(t_q[5], t_q[7]);
      5'd14:   f_d = bwpt_pkg::qsub(t_q[4], t_q[8]);
      5'd15:   f_d = bwpt_pkg::qsub(bwpt_pkg::QOne, bwpt_pkg::qadd(t_q[0], t_q[2]));
      5'd16:   f_d = bwpt_pkg::qadd(t_q[3], t_q[6]);
      5'd17:   f_d = bwpt_pkg::qadd(t_q[5], t_q[7]);
      5'd18:   f_d = bwpt_pkg::qsub(t_q[3], t_q[6]);
      5'd19:   f_d = bwpt_pkg::qsub(bwpt_pkg::QOne, bwpt_pkg::qadd(t_q[0], t_q[1]));
      default: f_d = f_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(mul_a) * 64'(mul_b);
    r_q    <= bwpt_pkg::qround(prod_q);
    if (ctrl_i.capture) begin
      x_q  <= rot_x_i;
      y_q  <= rot_y_i;
      z_q  <= rot_z_i;
      w_q  <= rot_w_i;
      x2_q <= bwpt_pkg::qadd(rot_x_i, rot_x_i);
      y2_q <= bwpt_pkg::qadd(rot_y_i, rot_y_i);
      z2_q <= bwpt_pkg::qadd(rot_z_i, rot_z_i);
      sx_q <= scale_x_i;
      sy_q <= scale_y_i;
      sz_q <= scale_z_i;
      px_q <= pos_x_i;
      py_q <= pos_y_i;
      pz_q <= pos_z_i;
    end
    if (load_run) begin
      if (st inside {[5'd2:5'd10]}) begin
        t_q[4'(st - 5'd2)] <= r_q;
      end
      f_q <= f_d;
    end
    if (bone_run) begin
      case (st)
        5'd2: acc_q <= r_q;
        5'd5: begin
          w0_q  <= bwpt_pkg::qadd(acc_q, m_q[9]);
          acc_q <= r_q;
        end
        5'd8: begin
          w1_q  <= bwpt_pkg::qadd(acc_q, m_q[10]);
          acc_q <= r_q;
        end
        5'd3, 5'd4, 5'd6, 5'd7, 5'd9, 5'd10: acc_q <= bwpt_pkg::qadd(acc_q, r_q);
        default: acc_q <= acc_q;
      endcase
    end
    if (ctrl_i.emit) begin
      world_q[0] <= w0_q;
      world_q[1] <= w1_q;
      world_q[2] <= bwpt_pkg::qadd(acc_q, m_q[11]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 12; i++) begin
        m_q[i] <= '0;
      end
    end else begin
      if (ctrl_i.capture && (cmd_i == bwpt_pkg::CmdLoad)) begin
        m_q[9]  <= pos_x_i;
        m_q[10] <= pos_y_i;
        m_q[11] <= pos_z_i;
      end
      if (load_run && (st inside {[5'd14:5'd22]})) begin
        m_q[4'(st - 5'd14)] <= r_q;
      end
    end
  end

  assign world_x_o = world_q[0];
  assign world_y_o = world_q[1];
  assign world_z_o = world_q[2];

endmodule

// File: rtl/bwpt_checker.sv
// Port-level checker for the bone world position transform and its bind statement.
module bwpt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        cmd_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] world_x_o,
  input logic [31:0] world_y_o,
  input logic [31:0] world_z_o
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(world_x_o) &&
    $stable(world_y_o) && $stable(world_z_o))
    else $error("result changed while stalled");

  // An accepted request keeps the block busy in the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  // A new result appears only as the block becomes free again.
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result shown while still busy");

  // A load request never produces a result right after acceptance.
  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !cmd_i |=> !$rose(out_valid_o))
    else $error("load request produced a result");

endmodule

bind bone_world_position_transform bwpt_checker u_bwpt_checker (.*);

// File: dv/bone_world_position_transform_test.sv
// Self-checking testbench for the bone world position transform, with a built-in fixed-point predictor.
module bone_world_position_transform_test;

  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned ReportLimit = 50;
  localparam int unsigned DrainCycles = 40;

  localparam logic signed [31:0] QTwo   = 32'sh0002_0000;
  localparam logic signed [31:0] QHalf  = 32'sh0000_8000;
  localparam logic signed [31:0] QRoot2 = 32'sd46341;

  typedef struct {
    logic               cmd;
    logic signed [31:0] qx, qy, qz, qw;
    logic signed [31:0] px, py, pz;
    logic signed [31:0] sx, sy, sz;
  } request_t;

  typedef struct {
    logic signed [31:0] x, y, z;
  } world_pos_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic               cmd       = bwpt_pkg::CmdLoad;
  logic signed [31:0] rot_x     = '0;
  logic signed [31:0] rot_y     = '0;
  logic signed [31:0] rot_z     = '0;
  logic signed [31:0] rot_w     = '0;
  logic signed [31:0] pos_x     = '0;
  logic signed [31:0] pos_y     = '0;
  logic signed [31:0] pos_z     = '0;
  logic signed [31:0] scale_x   = '0;
  logic signed [31:0] scale_y   = '0;
  logic signed [31:0] scale_z   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] world_x;
  logic signed [31:0] world_y;
  logic signed [31:0] world_z;

  logic signed [31:0] xform_m [12];
  world_pos_t         expected_world [$];
  int unsigned        errors = 0;
  int unsigned        quiet_cycles = 0;
  bit                 steady = 1'b0;

  bone_world_position_transform dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .cmd_i       (cmd),
    .rot_x_i     (rot_x),
    .rot_y_i     (rot_y),
    .rot_z_i     (rot_z),
    .rot_w_i     (rot_w),
    .pos_x_i     (pos_x),
    .pos_y_i     (pos_y),
    .pos_z_i     (pos_z),
    .scale_x_i   (scale_x),
    .scale_y_i   (scale_y),
    .scale_z_i   (scale_z),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .world_x_o   (world_x),
    .world_y_o   (world_y),
    .world_z_o   (world_z)
  );

  always #5 clk = ~clk;

  function automatic logic signed [31:0] clamp_q(input longint signed v);
    logic signed [31:0] r;
    if (v > longint'(bwpt_pkg::QMax)) begin
      r = bwpt_pkg::QMax;
    end else if (v < longint'(bwpt_pkg::QMin)) begin
      r = bwpt_pkg::QMin;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] fx_add(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    return clamp_q(longint'(a) + longint'(b));
  endfunction

  function automatic logic signed [31:0] fx_sub(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    return clamp_q(longint'(a) - longint'(b));
  endfunction

  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    longint signed p;
    p = longint'(a) * longint'(b) + 64'sd32768;
    return clamp_q(p >>> 16);
  endfunction

  function automatic void load_transform(input request_t r);
    logic signed [31:0] x2, y2, z2, xx2, yy2, zz2, yz2, xy2, xz2, wx2, wy2, wz2;
    x2  = fx_add(r.qx, r.qx);
    y2  = fx_add(r.qy, r.qy);
    z2  = fx_add(r.qz, r.qz);
    xx2 = fx_mul(r.qx, x2);
    yy2 = fx_mul(r.qy, y2);
    zz2 = fx_mul(r.qz, z2);
    yz2 = fx_mul(r.qy, z2);
    xy2 = fx_mul(r.qx, y2);
    xz2 = fx_mul(r.qx, z2);
    wx2 = fx_mul(r.qw, x2);
    wy2 = fx_mul(r.qw, y2);
    wz2 = fx_mul(r.qw, z2);
    xform_m[0]  = fx_mul(fx_sub(bwpt_pkg::QOne, fx_add(yy2, zz2)), r.sx);
    xform_m[1]  = fx_mul(fx_add(xy2, wz2), r.sx);
    xform_m[2]  = fx_mul(fx_sub(xz2, wy2), r.sx);
    xform_m[3]  = fx_mul(fx_sub(xy2, wz2), r.sy);
    xform_m[4]  = fx_mul(fx_sub(bwpt_pkg::QOne, fx_add(xx2, zz2)), r.sy);
    xform_m[5]  = fx_mul(fx_add(yz2, wx2), r.sy);
    xform_m[6]  = fx_mul(fx_add(xz2, wy2), r.sz);
    xform_m[7]  = fx_mul(fx_sub(yz2, wx2), r.sz);
    xform_m[8]  = fx_mul(fx_sub(bwpt_pkg::QOne, fx_add(xx2, yy2)), r.sz);
    xform_m[9]  = r.px;
    xform_m[10] = r.py;
    xform_m[11] = r.pz;
  endfunction

  function automatic world_pos_t project_bone(input request_t r);
    logic signed [31:0] acc [3];
    world_pos_t         w;
    for (int c = 0; c < 3; c++) begin
      acc[c] = fx_mul(r.px, xform_m[c]);
      acc[c] = fx_add(acc[c], fx_mul(r.py, xform_m[3 + c]));
      acc[c] = fx_add(acc[c], fx_mul(r.pz, xform_m[6 + c]));
      acc[c] = fx_add(acc[c], xform_m[9 + c]);
    end
    w.x = acc[0];
    w.y = acc[1];
    w.z = acc[2];
    return w;
  endfunction

  function automatic request_t make_request(
      input logic c,
      input logic signed [31:0] qx, qy, qz, qw,
      input logic signed [31:0] px, py, pz,
      input logic signed [31:0] sx, sy, sz);
    request_t r;
    r.cmd = c;
    r.qx = qx; r.qy = qy; r.qz = qz; r.qw = qw;
    r.px = px; r.py = py; r.pz = pz;
    r.sx = sx; r.sy = sy; r.sz = sz;
    return r;
  endfunction

  // Mostly values of a plausible size, with full-range words and corner values mixed in.
  function automatic logic signed [31:0] random_q(input int unsigned span);
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       v = bwpt_pkg::QMax;
          1:       v = bwpt_pkg::QMin;
          2:       v = '0;
          3:       v = bwpt_pkg::QOne;
          default: v = -bwpt_pkg::QOne;
        endcase
      end
      1, 2:    v = $urandom;
      default: v = int'($urandom_range(0, 2 * span)) - int'(span);
    endcase
    return v;
  endfunction

  function automatic request_t random_request(input bit load_only);
    request_t r;
    r.cmd = (load_only || $urandom_range(0, 5) == 0) ? bwpt_pkg::CmdLoad : bwpt_pkg::CmdBone;
    r.qx = random_q(32'h0001_0000);
    r.qy = random_q(32'h0001_0000);
    r.qz = random_q(32'h0001_0000);
    r.qw = random_q(32'h0001_0000);
    r.px = random_q(32'd65536000);
    r.py = random_q(32'd65536000);
    r.pz = random_q(32'd65536000);
    r.sx = random_q(32'h0004_0000);
    r.sy = random_q(32'h0004_0000);
    r.sz = random_q(32'h0004_0000);
    return r;
  endfunction

  function automatic bit take_gap();
    return !steady && $urandom_range(0, 99) < 26;
  endfunction

  task automatic report_error(input string msg);
    if (errors < ReportLimit) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
    errors++;
  endtask

  task automatic send_request(input request_t r);
    @(negedge clk);
    while (take_gap()) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    cmd     = r.cmd;
    rot_x   = r.qx;
    rot_y   = r.qy;
    rot_z   = r.qz;
    rot_w   = r.qw;
    pos_x   = r.px;
    pos_y   = r.py;
    pos_z   = r.pz;
    scale_x = r.sx;
    scale_y = r.sy;
    scale_z = r.sz;
    in_valid = 1'b1;
    do begin
      @(posedge clk);
    end while (!in_ready);
    if (r.cmd == bwpt_pkg::CmdLoad) begin
      load_transform(r);
    end else begin
      expected_world.insert(expected_world.size(), project_bone(r));
    end
  endtask

  task automatic wait_for_results();
    while (expected_world.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid = 1'b0;
    wait_for_results();
  endtask

  task automatic test_bone_without_load();
    send_request(make_request(bwpt_pkg::CmdBone, bwpt_pkg::QOne, bwpt_pkg::QOne,
                              bwpt_pkg::QOne, bwpt_pkg::QOne, bwpt_pkg::QMax,
                              bwpt_pkg::QMin, bwpt_pkg::QOne, bwpt_pkg::QOne,
                              bwpt_pkg::QOne, bwpt_pkg::QOne));
    send_request(make_request(bwpt_pkg::CmdBone, '0, '0, '0, '0, bwpt_pkg::QMin,
                              bwpt_pkg::QMax, bwpt_pkg::QMin, '0, '0, '0));
    send_request(make_request(bwpt_pkg::CmdBone, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
  endtask

  task automatic test_identity_load();
    send_request(make_request(bwpt_pkg::CmdLoad, '0, '0, '0, bwpt_pkg::QOne, QTwo,
                              -bwpt_pkg::QOne, QHalf, bwpt_pkg::QOne, bwpt_pkg::QOne,
                              bwpt_pkg::QOne));
    send_request(make_request(bwpt_pkg::CmdBone, '0, '0, '0, '0, bwpt_pkg::QOne, QTwo,
                              -QTwo, '0, '0, '0));
    send_request(make_request(bwpt_pkg::CmdBone, '0, '0, '0, '0, 32'sd12345, -32'sd98765,
                              32'sd1, '0, '0, '0));
  endtask

  task automatic test_rotation_and_scale();
    send_request(make_request(bwpt_pkg::CmdLoad, '0, '0, QRoot2, QRoot2, bwpt_pkg::QOne,
                              bwpt_pkg::QOne, bwpt_pkg::QOne, QTwo, QHalf,
                              -bwpt_pkg::QOne));
    send_request(make_request(bwpt_pkg::CmdBone, '0, '0, '0, '0, bwpt_pkg::QOne, '0, '0,
                              '0, '0, '0));
    send_request(make_request(bwpt_pkg::CmdBone, '0, '0, '0, '0, -QTwo, QHalf,
                              bwpt_pkg::QOne, '0, '0, '0));
  endtask

  task automatic test_non_unit_quaternion();
    send_request(make_request(bwpt_pkg::CmdLoad, QTwo, 32'sh0003_0000, -bwpt_pkg::QOne,
                              32'sh0005_0000, -QHalf, QTwo, '0, 32'sh0001_8000,
                              bwpt_pkg::QOne, -QTwo));
    send_request(make_request(bwpt_pkg::CmdBone, '0, '0, '0, '0, bwpt_pkg::QOne,
                              bwpt_pkg::QOne, bwpt_pkg::QOne, '0, '0, '0));
    send_request(make_request(bwpt_pkg::CmdBone, '0, '0, '0, '0, -QHalf, QTwo,
                              -bwpt_pkg::QOne, '0, '0, '0));
  endtask

  task automatic test_saturation();
    send_request(make_request(bwpt_pkg::CmdLoad, bwpt_pkg::QMax, bwpt_pkg::QMax,
                              bwpt_pkg::QMax, bwpt_pkg::QMax, bwpt_pkg::QMax,
                              bwpt_pkg::QMax, bwpt_pkg::QMax, bwpt_pkg::QMax,
                              bwpt_pkg::QMax, bwpt_pkg::QMax));
    send_request(make_request(bwpt_pkg::CmdBone, '0, '0, '0, '0, bwpt_pkg::QMax,
                              bwpt_pkg::QMax, bwpt_pkg::QMax, '0, '0, '0));
    send_request(make_request(bwpt_pkg::CmdBone, '0, '0, '0, '0, bwpt_pkg::QMin,
                              bwpt_pkg::QMin, bwpt_pkg::QMin, '0, '0, '0));
    send_request(make_request(bwpt_pkg::CmdLoad, bwpt_pkg::QMin, bwpt_pkg::QMin,
                              bwpt_pkg::QMin, bwpt_pkg::QMin, bwpt_pkg::QMin,
                              bwpt_pkg::QMin, bwpt_pkg::QMin, bwpt_pkg::QMin,
                              bwpt_pkg::QMin, bwpt_pkg::QMin));
    send_request(make_request(bwpt_pkg::CmdBone, '0, '0, '0, '0, bwpt_pkg::QMax,
                              bwpt_pkg::QMin, bwpt_pkg::QMax, '0, '0, '0));
    send_request(make_request(bwpt_pkg::CmdBone, '0, '0, '0, '0, bwpt_pkg::QMin,
                              bwpt_pkg::QMax, '0, '0, '0, '0));
  endtask

  task automatic test_back_to_back();
    steady = 1'b1;
    send_request(random_request(1'b1));
    for (int i = 0; i < 150; i++) begin
      send_request(random_request(1'b0));
    end
    steady = 1'b0;
  endtask

  task automatic test_random_mix();
    send_request(random_request(1'b1));
    for (int i = 1; i <= 1050; i++) begin
      send_request(random_request(1'b0));
      if (i % 250 == 0) begin
        hold_until_drained();
      end
    end
  endtask

  always @(negedge clk) begin
    out_ready = !(!steady && $urandom_range(0, 99) < 26);
  end

  always @(posedge clk) begin
    world_pos_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_world.size() == 0) begin
        report_error($sformatf("result with nothing expected: %h %h %h",
                               world_x, world_y, world_z));
      end else begin
        want = expected_world.pop_front();
        if (world_x !== want.x) begin
          report_error($sformatf("world_x got %h expected %h", world_x, want.x));
        end
        if (world_y !== want.y) begin
          report_error($sformatf("world_y got %h expected %h", world_y, want.y));
        end
        if (world_z !== want.z) begin
          report_error($sformatf("world_z got %h expected %h", world_z, want.z));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < 12; i++) begin
      xform_m[i] = '0;
    end
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_bone_without_load();
    test_identity_load();
    test_rotation_and_scale();
    test_non_unit_quaternion();
    test_saturation();
    test_back_to_back();
    test_random_mix();

    @(negedge clk);
    in_valid = 1'b0;
    wait_for_results();
    repeat (DrainCycles) @(posedge clk);
    if (expected_world.size() != 0) begin
      report_error($sformatf("%0d results never arrived", expected_world.size()));
    end
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: bone_world_position_transform.f
rtl/bwpt_pkg.sv
rtl/bwpt_ctrl.sv
rtl/bwpt_datapath.sv
rtl/bone_world_position_transform.sv
rtl/bwpt_checker.sv
dv/bone_world_position_transform_test.sv
